// ===== sv/multichannel_pixel_histogram_defines.svh =====
// assertion macros for the pixel histogram block
`ifndef MULTICHANNEL_PIXEL_HISTOGRAM_DEFINES_SVH
`define MULTICHANNEL_PIXEL_HISTOGRAM_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define MPH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define MPH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mph_pkg.sv =====
// shared types and constants of the pixel histogram block
package mph_pkg;

    localparam int DEF_MAX_BINS     = 256;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_COUNT_WIDTH  = 32;

    localparam int SAMPLE_W     = 16;
    localparam int TOTAL_W      = 32;
    localparam int OUT_COUNT_W  = 32;
    localparam int SAMPLE_LANES = 4;
    localparam int OUT_DATA_W   = OUT_COUNT_W + TOTAL_W + 2 * SAMPLE_W;

    localparam logic [1:0] CMD_ACC   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_FRAME = 2'd2;

    localparam logic [1:0] REG_SAMPLE_16 = 2'd0;
    localparam logic [1:0] REG_BINS      = 2'd1;
    localparam logic [1:0] REG_CHANNELS  = 2'd2;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FLD,
        ST_RDA,
        ST_UPD,
        ST_RDR,
        ST_RES,
        ST_FRM
    } t_state;

    typedef struct packed {
        logic mul;
        logic div;
        logic fold;
        logic rd_acc;
        logic rd_cmd;
        logic upd;
        logic clr;
        logic frame;
        logic wipe;
    } t_lane_ctl;

endpackage

// ===== sv/mph_lane.sv =====
// one channel lane: bin index divider, bin memory and channel statistics
module mph_lane
    import mph_pkg::*;
#(
    parameter int MAX_BINS    = DEF_MAX_BINS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_lane_ctl                    i_ctl,
    input  logic                         i_active,
    input  logic                         i_clr_sel,
    input  logic                         i_is16,
    input  logic [SAMPLE_W-1:0]          i_sample,
    input  logic [$clog2(MAX_BINS)-1:0]  i_nbm1,
    input  logic [$clog2(MAX_BINS)-1:0]  i_addr,
    output logic [COUNT_WIDTH-1:0]       o_count,
    output logic [TOTAL_W-1:0]           o_total,
    output logic [SAMPLE_W-1:0]          o_min,
    output logic [SAMPLE_W-1:0]          o_max
);

    localparam int AW = $clog2(MAX_BINS);
    localparam int PW = SAMPLE_W + AW;

    logic [COUNT_WIDTH-1:0] r_mem [MAX_BINS];
    logic [COUNT_WIDTH-1:0] r_rd;
    logic [PW-1:0]          r_rem;
    logic [AW-1:0]          r_quot;
    logic [SAMPLE_W-1:0]    r_v;
    logic [TOTAL_W-1:0]     r_total;
    logic [SAMPLE_W-1:0]    r_min;
    logic [SAMPLE_W-1:0]    r_max;

    logic [SAMPLE_W-1:0]    w_div;
    logic [PW-1:0]          w_hi;
    logic [PW-1:0]          w_lo;
    logic [PW-1:0]          w_sum;
    logic                   w_we;
    logic                   w_re;
    logic [AW-1:0]          w_waddr;
    logic [AW-1:0]          w_raddr;
    logic [COUNT_WIDTH-1:0] w_wdata;
    logic [COUNT_WIDTH-1:0] w_inc;

    assign w_div   = i_is16 ? 16'hFFFF : 16'h00FF;
    assign w_hi    = i_is16 ? (r_rem >> SAMPLE_W) : (r_rem >> (SAMPLE_W / 2));
    assign w_lo    = r_rem & PW'(w_div);
    assign w_sum   = w_hi + w_lo;
    assign w_inc   = (r_rd == '1) ? r_rd : r_rd + 1'b1;
    assign w_we    = i_ctl.wipe | (i_ctl.upd & i_active) | (i_ctl.clr & i_clr_sel);
    assign w_waddr = i_ctl.upd ? r_quot : i_addr;
    assign w_wdata = i_ctl.upd ? w_inc : '0;
    assign w_re    = i_ctl.rd_acc | i_ctl.rd_cmd;
    assign w_raddr = i_ctl.rd_acc ? r_quot : i_addr;

    // bin = product / maxcode with maxcode = 2^k - 1: the bits above k fold back
    // onto the low k bits twice, then one compare finishes the quotient
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_rem  <= PW'(i_sample) * PW'(i_nbm1);
            r_quot <= '0;
            r_v    <= i_sample;
        end else if (i_ctl.div) begin
            r_quot <= AW'(w_hi);
            r_rem  <= w_sum;
        end else if (i_ctl.fold) begin
            r_quot <= r_quot + AW'(w_hi) + AW'(w_sum >= PW'(w_div));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.frame) begin
            r_total <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else if (i_ctl.upd && i_active) begin
            if (r_total != '1) begin
                r_total <= r_total + 1'b1;
            end
            if (r_v < r_min) begin
                r_min <= r_v;
            end
            if (r_v > r_max) begin
                r_max <= r_v;
            end
        end
    end

    assign o_count = r_rd;
    assign o_total = r_total;
    assign o_min   = r_min;
    assign o_max   = r_max;

endmodule

// ===== sv/mph_merge.sv =====
// merge stage: selects the read channel among the lanes and holds the result
module mph_merge
    import mph_pkg::*;
#(
    parameter int NL          = SAMPLE_LANES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [COUNT_WIDTH-1:0] i_count [NL],
    input  logic [TOTAL_W-1:0]     i_total [NL],
    input  logic [SAMPLE_W-1:0]    i_min   [NL],
    input  logic [SAMPLE_W-1:0]    i_max   [NL],
    input  logic [1:0]             i_ch,
    input  logic                   i_bin_ok,
    input  logic                   i_load,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_DATA_W-1:0]  o_m_tdata
);

    localparam int WX = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;

    logic [COUNT_WIDTH-1:0] w_count;
    logic [WX-1:0]          w_cx;
    logic [OUT_COUNT_W-1:0] w_cnt32;
    logic [TOTAL_W-1:0]     w_total;
    logic [SAMPLE_W-1:0]    w_min;
    logic [SAMPLE_W-1:0]    w_max;
    logic                   r_valid;
    logic [OUT_DATA_W-1:0]  r_data;

    always_comb begin
        w_count = '0;
        w_total = '0;
        w_min   = '0;
        w_max   = '0;
        for (int c = 0; c < NL; c++) begin
            if (i_ch == 2'(c)) begin
                w_count = i_count[c];
                w_total = i_total[c];
                w_min   = i_min[c];
                w_max   = i_max[c];
            end
        end
    end

    always_comb begin
        w_cx = WX'(w_count);
        if (!i_bin_ok) begin
            w_cnt32 = '0;
        end else if (w_cx > WX'({OUT_COUNT_W{1'b1}})) begin
            w_cnt32 = '1;
        end else begin
            w_cnt32 = w_cx[OUT_COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {w_max, w_min, w_total, w_cnt32};
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

// ===== sv/multichannel_pixel_histogram.sv =====
// accumulate: multiply, two folds of the bin divide, bin read and write, in that order
// read: bin read, then the result is registered once the output slot is free
// start frame: clears the channel statistics; an unused command code is dropped
// reset: synchronous, active low; then a sweep clears every bin of the bin memories
// while no item is taken, configuration writes are taken at all times
module multichannel_pixel_histogram
    import mph_pkg::*;
#(
    parameter int MAX_BINS     = DEF_MAX_BINS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [8:0]            i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3, read_channel, read_bin,
    // clear_after_read, zero fill
    input  logic [79:0]           i_s_tdata,
    // command
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // bin_count, channel_total, channel_min, channel_max
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

`include "multichannel_pixel_histogram_defines.svh"

    localparam int AW  = $clog2(MAX_BINS);
    localparam int NBW = $clog2(MAX_BINS + 1);
    localparam int NL  = (MAX_CHANNELS < SAMPLE_LANES) ? MAX_CHANNELS : SAMPLE_LANES;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_cnt, n_cnt;
    logic                r_is16;
    logic [8:0]          r_bins;
    logic [2:0]          r_chans;
    logic [SAMPLE_W-1:0] r_samples [SAMPLE_LANES];
    logic [1:0]          r_rd_ch;
    logic [7:0]          r_rd_bin;
    logic                r_clr_flag;

    t_lane_ctl           w_ctl;
    logic                w_accept;
    logic                w_load;
    logic [NBW-1:0]      w_nb;
    logic [AW-1:0]       w_nbm1;
    logic [2:0]          w_nc;
    logic                w_bin_ok;
    logic                w_ch_ok;
    logic [AW-1:0]       w_addr;
    logic [NL-1:0]       w_act;
    logic [NL-1:0]       w_clr_sel;

    logic [COUNT_WIDTH-1:0] w_count [NL];
    logic [TOTAL_W-1:0]     w_total [NL];
    logic [SAMPLE_W-1:0]    w_min   [NL];
    logic [SAMPLE_W-1:0]    w_max   [NL];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is16  <= 1'b0;
            r_bins  <= 9'd256;
            r_chans <= 3'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SAMPLE_16: r_is16  <= i_cfg_data[0];
                REG_BINS:      r_bins  <= i_cfg_data;
                REG_CHANNELS:  r_chans <= i_cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        if (r_bins < 9'd2) begin
            w_nb = NBW'(2);
        end else if (32'(r_bins) > MAX_BINS) begin
            w_nb = NBW'(MAX_BINS);
        end else begin
            w_nb = NBW'(r_bins);
        end
        w_nbm1 = AW'(w_nb - 1'b1);
        if (r_chans == 3'd0) begin
            w_nc = 3'd1;
        end else if (r_chans > 3'(NL)) begin
            w_nc = 3'(NL);
        end else begin
            w_nc = r_chans;
        end
    end

    // 8-bit mode keeps only the low byte of each sample
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int c = 0; c < SAMPLE_LANES; c++) begin
                r_samples[c] <= r_is16 ? i_s_tdata[c*SAMPLE_W +: SAMPLE_W]
                                       : {8'h00, i_s_tdata[c*SAMPLE_W +: 8]};
            end
            r_rd_ch    <= i_s_tdata[65:64];
            r_rd_bin   <= i_s_tdata[73:66];
            r_clr_flag <= i_s_tdata[74];
        end
    end

    assign w_bin_ok = 32'(r_rd_bin) < 32'(w_nb);
    assign w_ch_ok  = 32'(r_rd_ch) < MAX_CHANNELS;
    assign w_addr   = (r_state == ST_WIPE) ? r_cnt : AW'(r_rd_bin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WIPE;
            r_cnt   <= AW'(MAX_BINS - 1);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_ctl   = '0;
        w_load  = 1'b0;
        case (r_state)
            ST_WIPE: begin
                w_ctl.wipe = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_s_tuser)
                        CMD_ACC:   n_state = ST_MUL;
                        CMD_READ:  n_state = ST_RDR;
                        CMD_FRAME: n_state = ST_FRM;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: begin
                w_ctl.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                w_ctl.div = 1'b1;
                n_state   = ST_FLD;
            end
            ST_FLD: begin
                w_ctl.fold = 1'b1;
                n_state    = ST_RDA;
            end
            ST_RDA: begin
                w_ctl.rd_acc = 1'b1;
                n_state      = ST_UPD;
            end
            ST_UPD: begin
                w_ctl.upd = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_RDR: begin
                w_ctl.rd_cmd = 1'b1;
                n_state      = ST_RES;
            end
            ST_RES: begin
                if (!o_m_tvalid || i_m_tready) begin
                    w_load    = 1'b1;
                    w_ctl.clr = r_clr_flag && w_bin_ok && w_ch_ok;
                    n_state   = ST_IDLE;
                end
            end
            ST_FRM: begin
                w_ctl.frame = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        assign w_act[g]     = 3'(g) < w_nc;
        assign w_clr_sel[g] = (r_rd_ch == 2'(g));

        mph_lane #(
            .MAX_BINS    (MAX_BINS),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_active  (w_act[g]),
            .i_clr_sel (w_clr_sel[g]),
            .i_is16    (r_is16),
            .i_sample  (r_samples[g]),
            .i_nbm1    (w_nbm1),
            .i_addr    (w_addr),
            .o_count   (w_count[g]),
            .o_total   (w_total[g]),
            .o_min     (w_min[g]),
            .o_max     (w_max[g])
        );
    end

    mph_merge #(
        .NL          (NL),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_count    (w_count),
        .i_total    (w_total),
        .i_min      (w_min),
        .i_max      (w_max),
        .i_ch       (r_rd_ch),
        .i_bin_ok   (w_bin_ok && w_ch_ok),
        .i_load     (w_load),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    `MPH_ASSERT_IMP(a_no_accept_in_wipe, r_state == ST_WIPE, !o_s_tready, "item taken during wipe")
    `MPH_ASSERT_IMP(a_load_free_slot, w_load, !o_m_tvalid || i_m_tready, "result overwritten")
    `MPH_ASSERT_NXT(a_acc_to_mul, w_accept && i_s_tuser == CMD_ACC, r_state == ST_MUL, "no mul")
    `MPH_ASSERT_NXT(a_div_fold, r_state == ST_DIV, r_state == ST_FLD, "fold skipped")
    `MPH_ASSERT_NXT(a_read_result, r_state == ST_RDR, r_state == ST_RES, "read lost")

endmodule
